[design/assert_macros.svh]
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/lmst_pkg.sv]
package lmst_pkg;

    localparam int LAG_BITS   = 16;
    localparam int COUNT_BITS = 20;
    localparam int SUM_BITS   = LAG_BITS + COUNT_BITS;
    localparam int SQ_BITS    = 2 * LAG_BITS + COUNT_BITS;
    localparam int ALU_BITS   = SQ_BITS;
    localparam int AVG_QBITS  = LAG_BITS;
    localparam int VAR_QBITS  = 2 * LAG_BITS;
    localparam int SQRT_STEPS = VAR_QBITS / 2;
    // scratch holds a division remainder or a square root remainder (< 2^(LAG_BITS+3))
    localparam int REM_BITS   = (COUNT_BITS > LAG_BITS + 3) ? COUNT_BITS : LAG_BITS + 3;
    localparam int ITER_BITS  = $clog2(VAR_QBITS);

    localparam logic [LAG_BITS-1:0] MAX_LAG_RESET = LAG_BITS'(2000);

    typedef logic [ALU_BITS-1:0] alu_word_t;
    typedef logic [REM_BITS-1:0] rem_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ADD_SUM,
        ST_ADD_SQ,
        ST_DIV_AVG,
        ST_MUL_PROD,
        ST_SUB_NUM,
        ST_DIV_VAR,
        ST_SQRT,
        ST_DONE
    } lmst_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } lmst_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } lmst_stat_t;

    typedef struct packed {
        logic [LAG_BITS-1:0] average;
        logic [LAG_BITS-1:0] deviation;
        logic                accepted;
    } lmst_res_t;

endpackage

[design/lmst_in_if.sv]
interface lmst_in_if import lmst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LAG_BITS-1:0] lag_ms;

    modport source (output valid, output lag_ms, input ready);
    modport sink (input valid, input lag_ms, output ready);
endinterface

[design/lmst_out_if.sv]
interface lmst_out_if import lmst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LAG_BITS-1:0] average_ms;
    logic [LAG_BITS-1:0] deviation_ms;
    logic                accepted;

    modport source (output valid, output average_ms, output deviation_ms, output accepted,
                    input ready);
    modport sink (input valid, input average_ms, input deviation_ms, input accepted,
                  output ready);
endinterface

[design/latency_mean_stddev_tracker.sv]
// Latency statistics tracker: each latency word on "sample" yields one word on "result"
// carrying the running integer mean, the integer sample standard deviation and a flag
// telling whether the sample was taken into the statistics (zero samples, samples above
// the max_lag register and samples after the count saturates are rejected). One sequencer
// drives a single shared 52-bit add/subtract unit through a square, two accumulates, the
// mean divide, the mean-times-sum product, the numerator subtract, the variance divide and
// a digit-by-digit square root; the first accepted sample only feeds the sums, a rejected
// one goes straight to the result, and sample.ready is low while a sample is in work. The
// result sits in an output register, so the next sample can be taken the cycle after the
// result is handed over, while it still waits. max_lag resets to 2000 and is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle, as
// the block itself does not enforce this.
`include "assert_macros.svh"

module latency_mean_stddev_tracker import lmst_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LAG_BITS-1:0] cfg_wr_data,
    lmst_in_if.sink             sample,
    lmst_out_if.source          result
);

    logic [LAG_BITS-1:0] max_lag_reg;
    logic                out_valid_reg, out_valid_next;
    lmst_res_t           out_res_reg;

    lmst_ctrl_t ctrl;
    lmst_stat_t stat;
    lmst_res_t  core_res;
    logic       core_ack;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lag_reg <= MAX_LAG_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_lag_reg <= cfg_wr_data;
        end
    end

    // the core hands its result over once the output register is free or draining
    assign core_ack     = stat.done && (!out_valid_reg || result.ready);
    assign ctrl.start   = sample.valid && stat.idle;
    assign ctrl.ack     = core_ack;
    assign sample.ready = stat.idle;

    lmst_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .lag     (sample.lag_ms),
        .max_lag (max_lag_reg),
        .stat    (stat),
        .res     (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (core_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_ack)
        begin
            out_res_reg <= core_res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.average_ms   = out_res_reg.average;
    assign result.deviation_ms = out_res_reg.deviation;
    assign result.accepted     = out_res_reg.accepted;

    // a taken sample puts the core to work
    `ASSERT_NEXT(a_start_busy, clk, rst_n, sample.valid && sample.ready, !stat.idle)
    // a handed-over result shows up on the output next cycle
    `ASSERT_NEXT(a_ack_loads, clk, rst_n, core_ack, result.valid)
    // a finished result never gets lost while the output is stalled
    `ASSERT_NEXT(a_done_holds, clk, rst_n, stat.done && !core_ack, stat.done)
    // no new sample while the core is done
    `ASSERT_NOW(a_no_start_done, clk, rst_n, stat.done, !sample.ready)

endmodule

[design/lmst_alu.sv]
// Shared add/subtract unit; carry high on subtract means a >= b.
module lmst_alu import lmst_pkg::*; (
    input  alu_word_t a,
    input  alu_word_t b,
    input  logic      sub,
    output alu_word_t y,
    output logic      carry
);

    logic [ALU_BITS:0] full;

    assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ALU_BITS{1'b0}}, sub};
    assign y     = full[ALU_BITS-1:0];
    assign carry = full[ALU_BITS];

endmodule

[design/lmst_core.sv]
// Sequencer and statistics datapath around the shared ALU.
module lmst_core import lmst_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  lmst_ctrl_t          ctrl,
    input  logic [LAG_BITS-1:0] lag,
    input  logic [LAG_BITS-1:0] max_lag,
    output lmst_stat_t          stat,
    output lmst_res_t           res
);

    localparam logic [ITER_BITS-1:0] LAST_MUL  = ITER_BITS'(LAG_BITS - 1);
    localparam logic [ITER_BITS-1:0] LAST_DIVA = ITER_BITS'(AVG_QBITS - 1);
    localparam logic [ITER_BITS-1:0] LAST_DIVV = ITER_BITS'(VAR_QBITS - 1);
    localparam logic [ITER_BITS-1:0] LAST_SQRT = ITER_BITS'(SQRT_STEPS - 1);

    lmst_state_t state_reg, state_next;
    logic [ITER_BITS-1:0]  iter_reg, iter_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [SQ_BITS-1:0]    sq_reg, sq_next;
    logic [LAG_BITS-1:0]   avg_hold_reg, avg_hold_next;
    logic [LAG_BITS-1:0]   dev_hold_reg, dev_hold_next;
    logic [LAG_BITS-1:0]   lag_reg, lag_next;
    logic                  take_reg, take_next;
    alu_word_t             acc_reg, acc_next;
    rem_word_t             rem_reg, rem_next;
    logic [LAG_BITS-1:0]   root_reg, root_next;

    alu_word_t alu_a, alu_b, alu_y;
    logic      alu_sub, alu_carry;

    logic                  take_now;
    logic                  iter_last;
    logic                  div_msb;
    logic [COUNT_BITS:0]   div_shift;
    logic [COUNT_BITS-1:0] divisor;
    logic                  mul_bit;
    alu_word_t             mcand;
    logic [LAG_BITS+2:0]   sqrt_shift;
    logic [LAG_BITS+1:0]   sqrt_trial;
    logic [LAG_BITS-1:0]   quo_avg;
    alu_word_t             num;

    assign take_now   = (lag != '0) && (lag <= max_lag) && !(&cnt_reg);
    assign div_msb    = (state_reg == ST_DIV_AVG) ? acc_reg[AVG_QBITS-1] : acc_reg[VAR_QBITS-1];
    assign div_shift  = {rem_reg[COUNT_BITS-1:0], div_msb};
    assign divisor    = (state_reg == ST_DIV_AVG) ? cnt_reg
                                                  : cnt_reg - {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign mul_bit    = rem_reg[LAG_BITS-1];
    assign mcand      = (state_reg == ST_SQUARE) ? alu_word_t'(lag_reg) : alu_word_t'(sum_reg);
    assign sqrt_shift = {rem_reg[LAG_BITS:0], acc_reg[VAR_QBITS-1:VAR_QBITS-2]};
    assign sqrt_trial = {root_reg, 2'b01};
    assign quo_avg    = {acc_reg[AVG_QBITS-2:0], alu_carry};
    assign num        = alu_carry ? alu_y : '0;

    always_comb
    begin
        case (state_reg)
            ST_SQUARE:   iter_last = (iter_reg == LAST_MUL);
            ST_MUL_PROD: iter_last = (iter_reg == LAST_MUL);
            ST_DIV_AVG:  iter_last = (iter_reg == LAST_DIVA);
            ST_DIV_VAR:  iter_last = (iter_reg == LAST_DIVV);
            ST_SQRT:     iter_last = (iter_reg == LAST_SQRT);
            default:     iter_last = 1'b0;
        endcase
    end

    // operand select for the shared unit
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg) inside
            ST_SQUARE, ST_MUL_PROD:
            begin
                alu_a = acc_reg << 1;
                alu_b = mul_bit ? mcand : '0;
            end
            ST_ADD_SUM:
            begin
                alu_a = alu_word_t'(sum_reg);
                alu_b = alu_word_t'(lag_reg);
            end
            ST_ADD_SQ:
            begin
                alu_a = alu_word_t'(sq_reg);
                alu_b = acc_reg;
            end
            ST_DIV_AVG, ST_DIV_VAR:
            begin
                alu_a   = alu_word_t'(div_shift);
                alu_b   = alu_word_t'(divisor);
                alu_sub = 1'b1;
            end
            ST_SUB_NUM:
            begin
                alu_a   = alu_word_t'(sq_reg);
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            ST_SQRT:
            begin
                alu_a   = alu_word_t'(sqrt_shift);
                alu_b   = alu_word_t'(sqrt_trial);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
            end
        endcase
    end

    lmst_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .y     (alu_y),
        .carry (alu_carry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (ctrl.start) state_next = take_now ? ST_SQUARE : ST_DONE;
            ST_SQUARE:   if (iter_last) state_next = ST_ADD_SUM;
            ST_ADD_SUM:  state_next = ST_ADD_SQ;
            ST_ADD_SQ:   state_next = (cnt_reg == COUNT_BITS'(1)) ? ST_DONE : ST_DIV_AVG;
            ST_DIV_AVG:  if (iter_last) state_next = ST_MUL_PROD;
            ST_MUL_PROD: if (iter_last) state_next = ST_SUB_NUM;
            ST_SUB_NUM:  state_next = ST_DIV_VAR;
            ST_DIV_VAR:  if (iter_last) state_next = ST_SQRT;
            ST_SQRT:     if (iter_last) state_next = ST_DONE;
            ST_DONE:     if (ctrl.ack) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        stat.idle    = (state_reg == ST_IDLE);
        stat.done    = (state_reg == ST_DONE);
        res.average  = avg_hold_reg;
        res.deviation = dev_hold_reg;
        res.accepted = take_reg;
    end

    // datapath
    always_comb
    begin
        iter_next     = '0;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        avg_hold_next = avg_hold_reg;
        dev_hold_next = dev_hold_reg;
        lag_next      = lag_reg;
        take_next     = take_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        case (state_reg) inside
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    lag_next  = lag;
                    take_next = take_now;
                    acc_next  = '0;
                    rem_next  = rem_word_t'(lag);
                end
            end
            ST_SQUARE, ST_MUL_PROD:
            begin
                iter_next = iter_last ? '0 : iter_reg + 1'b1;
                acc_next  = alu_y;
                rem_next  = rem_reg << 1;
            end
            ST_ADD_SUM:
            begin
                sum_next = alu_y[SUM_BITS-1:0];
                cnt_next = cnt_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
            ST_ADD_SQ:
            begin
                sq_next  = alu_y[SQ_BITS-1:0];
                // sum < count * 2^16, so the top part already sits below the divisor
                rem_next = rem_word_t'(sum_reg[SUM_BITS-1:AVG_QBITS]);
                acc_next = alu_word_t'(sum_reg[AVG_QBITS-1:0]);
            end
            ST_DIV_AVG, ST_DIV_VAR:
            begin
                iter_next = iter_last ? '0 : iter_reg + 1'b1;
                rem_next  = alu_carry ? rem_word_t'(alu_y[COUNT_BITS-1:0])
                                      : rem_word_t'(div_shift[COUNT_BITS-1:0]);
                acc_next  = {acc_reg[ALU_BITS-2:0], alu_carry};
                if (iter_last)
                begin
                    if (state_reg == ST_DIV_AVG)
                    begin
                        avg_hold_next = quo_avg;
                        rem_next      = rem_word_t'(quo_avg);
                        acc_next      = '0;
                    end
                    else
                    begin
                        rem_next  = '0;
                        root_next = '0;
                    end
                end
            end
            ST_SUB_NUM:
            begin
                // variance < 2^32, so the high part is below count-1
                rem_next = rem_word_t'(num[ALU_BITS-1:VAR_QBITS]);
                acc_next = alu_word_t'(num[VAR_QBITS-1:0]);
            end
            ST_SQRT:
            begin
                iter_next = iter_last ? '0 : iter_reg + 1'b1;
                rem_next  = alu_carry ? rem_word_t'(alu_y[LAG_BITS+2:0])
                                      : rem_word_t'(sqrt_shift);
                root_next = {root_reg[LAG_BITS-2:0], alu_carry};
                acc_next  = acc_reg << 2;
                if (iter_last)
                begin
                    dev_hold_next = {root_reg[LAG_BITS-2:0], alu_carry};
                end
            end
            default:
            begin
                iter_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            iter_reg     <= '0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            avg_hold_reg <= '0;
            dev_hold_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            iter_reg     <= iter_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            sq_reg       <= sq_next;
            avg_hold_reg <= avg_hold_next;
            dev_hold_reg <= dev_hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lag_reg  <= lag_next;
        take_reg <= take_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

[sim/tb_latency_mean_stddev_tracker.sv]
module tb_latency_mean_stddev_tracker;
    import lmst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog: cycles with no word moving on either channel. The limit is set
    // well above the arithmetic of an accepted sample plus the stall segments on
    // the result side.
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 10;

    // Stall pattern on the result side. Free running is the most common mode.
    typedef enum int {
        RDY_FREE,
        RDY_COIN,
        RDY_SPARSE,
        RDY_HOLD
    } ready_mode_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [LAG_BITS-1:0] cfg_wr_data;

    lmst_in_if  sample_ch ();
    lmst_out_if result_ch ();

    latency_mean_stddev_tracker u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample_ch),
        .result      (result_ch)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the statistics state, kept at the block's widths.
    // ------------------------------------------------------------------
    logic [LAG_BITS-1:0]   lag_limit;
    logic [COUNT_BITS-1:0] n_taken;
    logic [SUM_BITS-1:0]   lag_total;
    logic [SQ_BITS-1:0]    sq_total;
    logic [LAG_BITS-1:0]   mean_hold;
    logic [LAG_BITS-1:0]   spread_hold;

    logic [LAG_BITS-1:0] lag_backlog[$];   // samples waiting for the driver
    lmst_res_t           stats_q[$];       // expected result words, oldest first

    int          mismatches;
    int          quiet_cycles;
    int          burst_left;
    int          gap_left;
    int          ready_left;
    ready_mode_t ready_mode;
    int          cluster_mid;
    int          cluster_span;
    lmst_res_t   want;

    // floor(sqrt(v)), one root bit per step from the top down
    function automatic logic [31:0] int_sqrt(input logic [63:0] v);
        logic [31:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = 64'(root | (32'd1 << b));
            if (trial * trial <= v)
                root = root | (32'd1 << b);
        end
        return root;
    endfunction

    // Fold one handshaken sample word into the shadow state if it is accepted,
    // and queue the result word that the block must return for it.
    task automatic update_stats(input logic [LAG_BITS-1:0] lag);
        logic        take;
        logic [63:0] cnt;
        logic [63:0] avg;
        logic [63:0] prod;
        logic [63:0] num;
        logic [63:0] sd;
        lmst_res_t   res;
        take = (lag != '0) && (lag <= lag_limit) && (n_taken != {COUNT_BITS{1'b1}});
        if (take)
        begin
            n_taken   = n_taken + 1'b1;
            lag_total = lag_total + SUM_BITS'(lag);
            sq_total  = sq_total + SQ_BITS'(lag) * SQ_BITS'(lag);
            // first sample only feeds the sums; held values stay put
            if (n_taken >= 2)
            begin
                cnt  = 64'(n_taken);
                avg  = 64'(lag_total) / cnt;
                prod = avg * 64'(lag_total);
                num  = (64'(sq_total) >= prod) ? 64'(sq_total) - prod : 64'd0;
                sd   = 64'(int_sqrt(num / (cnt - 1)));
                mean_hold   = (avg > 64'hFFFF) ? 16'hFFFF : avg[15:0];
                spread_hold = (sd > 64'hFFFF) ? 16'hFFFF : sd[15:0];
            end
        end
        res.average   = mean_hold;
        res.deviation = spread_hold;
        res.accepted  = take;
        stats_q.push_back(res);
    endtask

    // Random sample for the current max_lag: mostly legal samples, either
    // clustered (small spread) or spread over the whole range, plus zeros,
    // over-limit samples and both ends of the legal range.
    function automatic logic [LAG_BITS-1:0] pick_lag();
        int lim;
        int roll;
        int v;
        lim  = int'(lag_limit);
        roll = $urandom_range(0, 99);
        if (lim == 0)
            return 16'($urandom_range(0, 65535));
        if (roll < 6)
            return '0;
        if (roll < 14)
            return (lim == 65535) ? 16'($urandom_range(1, 65535))
                                  : 16'($urandom_range(lim + 1, 65535));
        if (roll < 24)
            return $urandom_range(0, 1) ? 16'(lim) : 16'd1;
        if (roll < 60)
        begin
            v = cluster_mid - cluster_span + int'($urandom_range(0, 2 * cluster_span));
            if (v < 1)
                v = 1;
            if (v > lim)
                v = lim;
            return 16'(v);
        end
        return 16'($urandom_range(1, lim));
    endfunction

    // Register write; only called with nothing in flight.
    task automatic write_max_lag(input logic [LAG_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        lag_limit   = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Hold off until the backlog is sent and every result word is back,
    // then give a rejected sample's short pipeline time to clear.
    task automatic settle();
        while (lag_backlog.size() != 0 || sample_ch.valid || stats_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic random_phase(input logic [LAG_BITS-1:0] limit, input int count);
        write_max_lag(limit);
        cluster_mid  = (limit == '0) ? 1 : int'($urandom_range(1, int'(limit)));
        cluster_span = $urandom_range(0, 64);
        repeat (count) lag_backlog.push_back(pick_lag());
        settle();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sample driver: bursts of random length, random gaps between them,
    // and some bursts back to back with no gap at all.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_samples
        logic                next_valid;
        logic [LAG_BITS-1:0] next_lag;
        if (!rst_n)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.lag_ms <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                update_stats(sample_ch.lag_ms);
            // a word still waiting for ready is held as it is
            if (!sample_ch.valid || sample_ch.ready)
            begin
                next_valid = 1'b0;
                next_lag   = sample_ch.lag_ms;
                if (gap_left > 0)
                    gap_left--;
                else if (lag_backlog.size() != 0)
                begin
                    next_valid = 1'b1;
                    next_lag   = lag_backlog.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 11);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
                sample_ch.valid  <= next_valid;
                sample_ch.lag_ms <= next_lag;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each word against the oldest expectation,
    // and drives ready from a segmented stall pattern.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        logic rdy;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            ready_left = 0;
            ready_mode = RDY_FREE;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (stats_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: avg=%0d dev=%0d acc=%0b",
                             $time, result_ch.average_ms, result_ch.deviation_ms,
                             result_ch.accepted);
                    mismatches++;
                end
                else
                begin
                    want = stats_q.pop_front();
                    if (result_ch.average_ms !== want.average)
                    begin
                        $display("%0t: average_ms expected %0d, got %0d",
                                 $time, want.average, result_ch.average_ms);
                        mismatches++;
                    end
                    if (result_ch.deviation_ms !== want.deviation)
                    begin
                        $display("%0t: deviation_ms expected %0d, got %0d",
                                 $time, want.deviation, result_ch.deviation_ms);
                        mismatches++;
                    end
                    if (result_ch.accepted !== want.accepted)
                    begin
                        $display("%0t: accepted expected %0b, got %0b",
                                 $time, want.accepted, result_ch.accepted);
                        mismatches++;
                    end
                end
            end
            if (ready_left == 0)
            begin
                case ($urandom_range(0, 5)) inside
                    [0:2]:   ready_mode = RDY_FREE;
                    3:       ready_mode = RDY_COIN;
                    4:       ready_mode = RDY_SPARSE;
                    default: ready_mode = RDY_HOLD;
                endcase
                ready_left = $urandom_range(5, 40);
            end
            else
                ready_left--;
            case (ready_mode)
                RDY_FREE:   rdy = 1'b1;
                RDY_COIN:   rdy = 1'($urandom_range(0, 1));
                RDY_SPARSE: rdy = ($urandom_range(0, 7) == 0);
                default:    rdy = 1'b0;
            endcase
            result_ch.ready <= rdy;
        end
    end

    // Watchdog on handshake activity.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("** latency_mean_stddev_tracker: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus sequence. Each phase ends with a full drain, which is also
    // where max_lag gets rewritten.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.lag_ms = '0;
        result_ch.ready  = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        lag_limit    = MAX_LAG_RESET;
        n_taken      = '0;
        lag_total    = '0;
        sq_total     = '0;
        mean_hold    = '0;
        spread_hold  = '0;
        cluster_mid  = 1;
        cluster_span = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset limit of 2000: zero before any take, a lone first sample
        // (held values stay zero), just above and exactly at the limit,
        // the top code, then zero and one once stats exist
        lag_backlog = '{16'd0, 16'd5, 16'd2001, 16'd2000, 16'hFFFF, 16'd0, 16'd1};
        settle();

        // limit zero rejects everything
        write_max_lag(16'd0);
        lag_backlog = '{16'd1, 16'hFFFF, 16'd0};
        settle();

        // full range: alternating extremes push the deviation near its top
        write_max_lag(16'hFFFF);
        lag_backlog = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'h8000, 16'd0};
        settle();

        // limit one: only the sample 1 passes
        write_max_lag(16'd1);
        lag_backlog = '{16'd1, 16'd2, 16'd1};
        settle();

        random_phase(16'hFFFF, 120);
        random_phase(MAX_LAG_RESET, 110);
        random_phase(16'($urandom_range(2, 65534)), 100);
        random_phase(16'd1, 30);
        random_phase(16'd300, 100);
        random_phase(16'd0, 20);
        random_phase(16'($urandom_range(2, 65534)), 100);
        random_phase(16'hFFFF, 120);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (stats_q.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, stats_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("** latency_mean_stddev_tracker: PASSED **");
        else
            $display("** latency_mean_stddev_tracker: FAILED **");
        $finish;
    end

endmodule
